// File: hdl/drl_pkg.sv
// ----------------------------------------------------------------------------
// drl_pkg
// Types and codes shared by the data-run list decoder and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package drl_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_END   = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  localparam int unsigned LEN_W     = 63;
  localparam int unsigned CLUSTER_W = 64;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;
  localparam logic [7:0] END_HEADER  = 8'h00;

endpackage

`default_nettype wire

// File: hdl/drl_if.sv
// ----------------------------------------------------------------------------
// drl_in_if / drl_out_if
// Valid/ready channels carrying run-list bytes in and decoded runs out.
// ----------------------------------------------------------------------------
`default_nettype none

interface drl_in_if
  import drl_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] run_byte;
  logic       list_start;
  logic       buffer_end;

  modport source (output valid, output run_byte, output list_start, output buffer_end,
                  input ready);
  modport sink   (input valid, input run_byte, input list_start, input buffer_end,
                  output ready);
endinterface

interface drl_out_if
  import drl_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [LEN_W-1:0]            run_length;
  logic signed [CLUSTER_W-1:0] run_cluster;
  logic                        is_sparse;
  status_t                     status;
  logic                        list_done;

  modport source (output valid, output run_length, output run_cluster, output is_sparse,
                  output status, output list_done, input ready);
  modport sink   (input valid, input run_length, input run_cluster, input is_sparse,
                  input status, input list_done, output ready);
endinterface

`default_nettype wire

// File: hdl/data_run_list_decoder.sv
// ----------------------------------------------------------------------------
// data_run_list_decoder
// Decodes a file-system data-run list (mapping pairs) one byte per request.
//
// in_ch takes one list byte per request, with list_start on the first byte
// of a list and buffer_end on the last byte available. out_ch gives at most
// one result per byte: a decoded run (length, absolute start cluster, sparse
// flag), an end-of-list marker or an error, with list_done on the last one.
// A byte is held in an input register, then decoded into the output register,
// which takes the result once out_ch can advance. One byte is taken every
// cycle while out_ch keeps up. The decode cycle is a byte insert, a sign
// extension and one 64-bit add of the cluster number. When the receiver
// stalls with a result pending, the held byte waits and in_ch drops ready
// once the input register is full; nothing is lost. Reset empties both
// registers and leaves the decoder expecting a header with the cluster
// number at zero. Bytes after the end of a list are dropped until
// list_start is seen.
// ----------------------------------------------------------------------------
`default_nettype none

module data_run_list_decoder
  import drl_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  drl_in_if.sink     in_ch,
  drl_out_if.source  out_ch
);

  localparam int unsigned ACC_W = 8 * MAX_FIELD_BYTES;
  localparam int unsigned POS_W = $clog2(MAX_FIELD_BYTES + 1);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       s1_last_r;

  // decoder state
  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   lb_r, lb_nxt;
  logic [POS_W-1:0]   ob_r, ob_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [ACC_W-1:0]   len_acc_r, len_acc_nxt;
  logic [ACC_W-1:0]   delta_acc_r, delta_acc_nxt;
  logic [CLUSTER_W-1:0] cluster_r, cluster_nxt;

  // output register
  logic                 out_valid_r;
  logic [LEN_W-1:0]     out_len_r, out_len_nxt;
  logic [CLUSTER_W-1:0] out_cluster_r, out_cluster_nxt;
  logic                 out_sparse_r, out_sparse_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_done_r, out_done_nxt;
  logic                 emit;

  logic advance, s1_fire, in_fire;

  assign advance      = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // decode conditions
  phase_t               cur_phase;
  logic [3:0]           hdr_ls, hdr_os;
  logic                 hdr_bad;
  logic [POS_W-1:0]     pos_inc;
  logic [ACC_W-1:0]     len_ins, delta_ins;
  logic [CLUSTER_W-1:0] len64, delta_ext, cluster_base, cluster_sum;
  logic                 len_bad, len_done, off_done, delta_sign;

  assign cur_phase = s1_start_r ? PH_HEADER : phase_r;
  assign hdr_ls    = s1_byte_r[3:0] & NIBBLE_MASK;
  assign hdr_os    = s1_byte_r[7:4] & NIBBLE_MASK;
  assign hdr_bad   = (hdr_ls == 4'd0) || (32'(hdr_ls) > MAX_FIELD_BYTES)
                     || (32'(hdr_os) > MAX_FIELD_BYTES) || s1_last_r;
  assign pos_inc   = pos_r + POS_W'(1);

  always_comb begin
    len_ins   = len_acc_r;
    delta_ins = delta_acc_r;
    for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
      if (pos_r == POS_W'(i)) begin
        len_ins[8*i +: 8]   = s1_byte_r;
        delta_ins[8*i +: 8] = s1_byte_r;
      end
    end
  end

  assign len64    = CLUSTER_W'(len_ins);
  assign len_bad  = (len64 == '0) || len64[CLUSTER_W-1];
  assign len_done = pos_inc >= lb_r;
  assign off_done = pos_inc >= ob_r;

  always_comb begin
    delta_sign = 1'b0;
    for (int k = 1; k <= MAX_FIELD_BYTES; k++) begin
      if (ob_r == POS_W'(k)) begin
        delta_sign = delta_ins[8*k-1];
      end
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_ext
    if (j < MAX_FIELD_BYTES) begin : g_lane
      assign delta_ext[8*j +: 8] = (ob_r > POS_W'(j)) ? delta_ins[8*j +: 8]
                                                       : {8{delta_sign}};
    end else begin : g_sign
      assign delta_ext[8*j +: 8] = {8{delta_sign}};
    end
  end

  assign cluster_base = s1_start_r ? '0 : cluster_r;
  assign cluster_sum  = cluster_r + delta_ext;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (s1_fire) begin
      unique case (cur_phase)
        PH_HEADER: begin
          if (s1_byte_r == END_HEADER || hdr_bad) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (len_done) begin
            if (len_bad || s1_last_r) begin
              phase_nxt = PH_IDLE;
            end else if (ob_r == '0) begin
              phase_nxt = PH_HEADER;
            end else begin
              phase_nxt = PH_OFFSET;
            end
          end else if (s1_last_r) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_OFFSET: begin
          if (s1_last_r) begin
            phase_nxt = PH_IDLE;
          end else if (off_done) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_IDLE: phase_nxt = PH_IDLE;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    lb_nxt          = lb_r;
    ob_nxt          = ob_r;
    pos_nxt         = pos_r;
    len_acc_nxt     = len_acc_r;
    delta_acc_nxt   = delta_acc_r;
    cluster_nxt     = cluster_base;
    emit            = 1'b0;
    out_len_nxt     = '0;
    out_cluster_nxt = '0;
    out_sparse_nxt  = 1'b0;
    out_status_nxt  = ST_ERROR;
    out_done_nxt    = 1'b1;
    if (!s1_fire) begin
      cluster_nxt = cluster_r;
    end else begin
      unique case (cur_phase)
        PH_HEADER: begin
          if (s1_byte_r == END_HEADER) begin
            emit           = 1'b1;
            out_status_nxt = ST_END;
          end else if (hdr_bad) begin
            emit = 1'b1;
          end else begin
            lb_nxt        = POS_W'(hdr_ls);
            ob_nxt        = POS_W'(hdr_os);
            pos_nxt       = '0;
            len_acc_nxt   = '0;
            delta_acc_nxt = '0;
          end
        end
        PH_LENGTH: begin
          len_acc_nxt = len_ins;
          pos_nxt     = pos_inc;
          if (len_done) begin
            if (len_bad) begin
              emit = 1'b1;
            end else if (ob_r == '0) begin
              emit           = 1'b1;
              out_len_nxt    = len64[LEN_W-1:0];
              out_sparse_nxt = 1'b1;
              out_status_nxt = ST_RUN;
              out_done_nxt   = s1_last_r;
            end else if (s1_last_r) begin
              emit = 1'b1;
            end else begin
              pos_nxt       = '0;
              delta_acc_nxt = '0;
            end
          end else if (s1_last_r) begin
            emit = 1'b1;
          end
        end
        PH_OFFSET: begin
          delta_acc_nxt = delta_ins;
          pos_nxt       = pos_inc;
          if (off_done) begin
            emit            = 1'b1;
            cluster_nxt     = cluster_sum;
            out_len_nxt     = CLUSTER_W'(len_acc_r) >> 0 == '0 ? '0
                              : LEN_W'(len_acc_r);
            out_cluster_nxt = cluster_sum;
            out_status_nxt  = ST_RUN;
            out_done_nxt    = s1_last_r;
          end else if (s1_last_r) begin
            emit = 1'b1;
          end
        end
        PH_IDLE: begin
          emit = 1'b0;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HEADER;
      lb_r        <= '0;
      ob_r        <= '0;
      pos_r       <= '0;
      len_acc_r   <= '0;
      delta_acc_r <= '0;
      cluster_r   <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_fire && emit;
      end
      phase_r     <= phase_nxt;
      lb_r        <= lb_nxt;
      ob_r        <= ob_nxt;
      pos_r       <= pos_nxt;
      len_acc_r   <= len_acc_nxt;
      delta_acc_r <= delta_acc_nxt;
      cluster_r   <= cluster_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_ch.run_byte;
      s1_start_r <= in_ch.list_start;
      s1_last_r  <= in_ch.buffer_end;
    end
    if (s1_fire && emit) begin
      out_len_r     <= out_len_nxt;
      out_cluster_r <= out_cluster_nxt;
      out_sparse_r  <= out_sparse_nxt;
      out_status_r  <= out_status_nxt;
      out_done_r    <= out_done_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.run_length  = out_len_r;
  assign out_ch.run_cluster = out_cluster_r;
  assign out_ch.is_sparse   = out_sparse_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.list_done   = out_done_r;

endmodule

`default_nettype wire

// File: tb/data_run_list_decoder_tb.sv
// ----------------------------------------------------------------------------
// data_run_list_decoder_tb
// Sends data-run lists byte by byte through the input channel and checks every
// decoded run, list end and error against a predictor of the mapping-pair
// decoder. Short directed lists come first, then random lists built mostly of
// well-formed pairs, with random gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module data_run_list_decoder_tb;
  import drl_pkg::*;

  localparam int unsigned ITEM_TARGET = 1000;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct {
    logic [LEN_W-1:0]     length;
    logic [CLUSTER_W-1:0] cluster;
    logic                 sparse;
    status_t              status;
    logic                 done;
  } decoded_run_t;

  typedef struct {
    logic [7:0] b;
    bit         s;
    bit         e;
  } list_byte_t;

  class mapping_pair_predictor;
    phase_t         phase;
    logic [3:0]     len_size;
    logic [3:0]     off_size;
    logic [3:0]     pos;
    logic [63:0]    len_acc;
    logic [63:0]    delta_acc;
    logic [63:0]    cluster_acc;
    decoded_run_t   pending_runs[$];
    int unsigned    mismatches;
    int unsigned    n_checked;
    int unsigned    n_runs;
    int unsigned    n_sparse;
    int unsigned    n_ends;
    int unsigned    n_errors;

    function new();
      phase       = PH_HEADER;
      len_size    = '0;
      off_size    = '0;
      pos         = '0;
      len_acc     = '0;
      delta_acc   = '0;
      cluster_acc = '0;
      mismatches  = 0;
      n_checked   = 0;
      n_runs      = 0;
      n_sparse    = 0;
      n_ends      = 0;
      n_errors    = 0;
    endfunction

    function void push_run(logic [63:0] len, logic [63:0] clus, logic sparse, status_t st,
                           logic done);
      decoded_run_t r;
      r.length  = len[LEN_W-1:0];
      r.cluster = clus;
      r.sparse  = sparse;
      r.status  = st;
      r.done    = done;
      pending_runs = {pending_runs, r};
    endfunction

    function void abort_list();
      phase = PH_IDLE;
      push_run('0, '0, 1'b0, ST_ERROR, 1'b1);
    endfunction

    function void close_pair(bit last);
      int unsigned nbits;
      phase = last ? PH_IDLE : PH_HEADER;
      if (off_size == 0) begin
        push_run(len_acc, '0, 1'b1, ST_RUN, last);
        return;
      end
      if (off_size < 8) begin
        nbits = 8 * off_size;
        if (delta_acc[nbits-1])
          delta_acc = delta_acc | (~64'd0 << nbits);
      end
      cluster_acc = cluster_acc + delta_acc;
      push_run(len_acc, cluster_acc, 1'b0, ST_RUN, last);
    endfunction

    // one accepted request on the input channel
    function void take_byte(logic [7:0] b, bit start, bit last);
      if (start) begin
        cluster_acc = '0;
        len_acc     = '0;
        delta_acc   = '0;
        pos         = '0;
        phase       = PH_HEADER;
      end else if (phase == PH_IDLE) begin
        return;
      end
      case (phase)
        PH_HEADER: begin
          if (b == END_HEADER) begin
            phase = PH_IDLE;
            push_run('0, '0, 1'b0, ST_END, 1'b1);
          end else if (b[3:0] == 0 || b[3:0] > 8 || b[7:4] > 8 || last) begin
            abort_list();
          end else begin
            len_size  = b[3:0];
            off_size  = b[7:4];
            pos       = '0;
            len_acc   = '0;
            delta_acc = '0;
            phase     = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          len_acc = len_acc | ({56'd0, b} << (8 * pos[2:0]));
          pos     = pos + 4'd1;
          if (pos >= len_size) begin
            if (len_acc == 0 || len_acc[63])
              abort_list();
            else if (off_size == 0)
              close_pair(last);
            else if (last)
              abort_list();
            else begin
              pos       = '0;
              delta_acc = '0;
              phase     = PH_OFFSET;
            end
          end else if (last) begin
            abort_list();
          end
        end
        default: begin
          delta_acc = delta_acc | ({56'd0, b} << (8 * pos[2:0]));
          pos       = pos + 4'd1;
          if (pos >= off_size)
            close_pair(last);
          else if (last)
            abort_list();
        end
      endcase
    endfunction

    // one accepted request on the result channel
    function void check_run(logic [LEN_W-1:0] length, logic [CLUSTER_W-1:0] cluster,
                            logic sparse, status_t status, logic done);
      decoded_run_t want;
      n_checked++;
      if (pending_runs.size() == 0) begin
        $error("result with no decoded run pending (status %0d)", status);
        mismatches++;
        return;
      end
      want = pending_runs.pop_front();
      if (length !== want.length) begin
        $error("run_length: expected %0d, got %0d", want.length, length);
        mismatches++;
      end
      if (cluster !== want.cluster) begin
        $error("run_cluster: expected %0d, got %0d", $signed(want.cluster), $signed(cluster));
        mismatches++;
      end
      if (sparse !== want.sparse) begin
        $error("is_sparse: expected %0d, got %0d", want.sparse, sparse);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (done !== want.done) begin
        $error("list_done: expected %0d, got %0d", want.done, done);
        mismatches++;
      end
      case (want.status)
        ST_RUN: begin
          n_runs++;
          if (want.sparse)
            n_sparse++;
        end
        ST_END:  n_ends++;
        default: n_errors++;
      endcase
    endfunction
  endclass

  logic clk;
  logic rst_n;

  drl_in_if  in_ch ();
  drl_out_if out_ch ();

  data_run_list_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mapping_pair_predictor pair_pred;
  list_byte_t            stream[$];
  bit                    start_pending;
  bit                    no_gaps;
  int unsigned           bytes_sent;
  int unsigned           lists_sent;
  int unsigned           idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void begin_list();
    start_pending = 1'b1;
    lists_sent++;
  endfunction

  function automatic void put(logic [7:0] b, bit e);
    list_byte_t item;
    item.b = b;
    item.s = start_pending;
    item.e = e;
    stream = {stream, item};
    start_pending = 1'b0;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // one well-formed pair, occasionally with a zero length
  function automatic void put_pair(bit close_buffer);
    int unsigned lsz;
    int unsigned osz;
    int unsigned k;
    bit          zero_len;
    lsz = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 8);
    if ($urandom_range(0, 6) == 0)
      osz = 0;
    else
      osz = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 8);
    zero_len = ($urandom_range(0, 29) == 0);
    put({4'(osz), 4'(lsz)}, 1'b0);
    for (k = 0; k < lsz; k++)
      put(zero_len ? 8'h00 : rand_byte(), close_buffer && osz == 0 && k == lsz - 1);
    for (k = 0; k < osz; k++)
      put(rand_byte(), close_buffer && k == osz - 1);
  endfunction

  function automatic void build_random_list();
    int unsigned npairs;
    int unsigned ending;
    int unsigned k;
    int unsigned need;
    int unsigned cut;
    logic [7:0]  hdr;
    begin_list();
    npairs = $urandom_range(0, 5);
    ending = $urandom_range(0, 99);
    for (k = 0; k < npairs; k++) begin
      if ($urandom_range(0, 24) == 0)
        put(rand_byte(), $urandom_range(0, 9) == 0);
      else
        put_pair(ending >= 70 && ending < 82 && k == npairs - 1);
    end
    if (ending < 70 || (ending < 82 && npairs == 0)) begin
      put(END_HEADER, $urandom_range(0, 3) == 0);
    end else if (ending >= 82 && ending < 90) begin
      // buffer runs out inside a pair
      hdr  = {4'($urandom_range(0, 8)), 4'($urandom_range(1, 8))};
      need = hdr[3:0] + hdr[7:4];
      cut  = $urandom_range(0, need - 1);
      put(hdr, cut == 0);
      if (cut != 0) begin
        for (k = 1; k < cut; k++)
          put(rand_byte(), 1'b0);
        put(rand_byte(), 1'b1);
      end
    end else if (ending >= 90) begin
      // abandoned mid-pair, the next list restarts
      put({4'($urandom_range(0, 8)), 4'($urandom_range(2, 8))}, 1'b0);
      put(rand_byte(), 1'b0);
    end
    if ($urandom_range(0, 9) == 0) begin
      need = $urandom_range(1, 3);
      for (k = 0; k < need; k++)
        put(rand_byte(), 1'($urandom_range(0, 1)));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit start, input bit last);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.run_byte   <= b;
    in_ch.list_start <= start;
    in_ch.buffer_end <= last;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    pair_pred.take_byte(b, start, last);
    bytes_sent++;
  endtask

  task automatic play_stream();
    list_byte_t lb;
    while (stream.size() != 0) begin
      lb = stream.pop_front();
      send_byte(lb.b, lb.s, lb.e);
    end
  endtask

  // receiver: long ready stretches, short and occasional long stalls
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    repeat (2) @(posedge clk);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      pair_pred.check_run(out_ch.run_length, out_ch.run_cluster, out_ch.is_sparse,
                          out_ch.status, out_ch.list_done);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    idle_cycles       = 0;
    bytes_sent        = 0;
    lists_sent        = 0;
    no_gaps           = 1'b0;
    start_pending     = 1'b0;
    pair_pred         = new();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.run_byte   <= 8'h00;
    in_ch.list_start <= 1'b0;
    in_ch.buffer_end <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty list
    begin_list();
    put(END_HEADER, 1'b0);
    // a run whose delta wraps the cluster below zero, a sparse run, then the end
    begin_list();
    put(8'h11, 1'b0);
    put(8'h05, 1'b0);
    put(8'hFF, 1'b0);
    put(8'h01, 1'b0);
    put(8'h03, 1'b0);
    put(END_HEADER, 1'b0);
    // byte after the end is dropped
    put(8'h55, 1'b0);
    // bad headers: no length field, oversized length, oversized offset, all ones
    begin_list();
    put(8'h10, 1'b0);
    begin_list();
    put(8'h19, 1'b0);
    begin_list();
    put(8'h91, 1'b0);
    begin_list();
    put(8'hFF, 1'b0);
    // header is the last byte in the buffer
    begin_list();
    put(8'h11, 1'b1);
    // zero run length
    begin_list();
    put(8'h01, 1'b0);
    put(8'h00, 1'b0);
    // buffer ends inside the offset field
    begin_list();
    put(8'h21, 1'b0);
    put(8'h02, 1'b0);
    put(8'h34, 1'b1);
    // restart mid-pair, then a run that closes the buffer on its last byte
    begin_list();
    put(8'h21, 1'b0);
    put(8'h07, 1'b0);
    begin_list();
    put(8'h11, 1'b0);
    put(8'h01, 1'b0);
    put(8'h80, 1'b1);
    play_stream();

    while (bytes_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      build_random_list();
      play_stream();
    end
    in_ch.valid <= 1'b0;

    while (pair_pred.pending_runs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pair_pred.pending_runs.size() != 0) begin
      $error("%0d decoded runs never arrived", pair_pred.pending_runs.size());
      pair_pred.mismatches++;
    end

    $display("%0d list bytes sent in %0d lists, %0d results checked",
             bytes_sent, lists_sent, pair_pred.n_checked);
    $display("%0d runs (%0d sparse), %0d list ends, %0d error ends",
             pair_pred.n_runs, pair_pred.n_sparse, pair_pred.n_ends, pair_pred.n_errors);
    if (pair_pred.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/drl_pkg.sv
hdl/drl_if.sv
hdl/data_run_list_decoder.sv
tb/data_run_list_decoder_tb.sv
